@@ rtl/vsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_pkg: shared types and constants of the varint stream decoder
// Beat layouts of both channels, status codes and format limits.
// ----------------------------------------------------------------------------
package vsd_pkg;

  // Status codes of a result beat.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusTooLong   = 2'd1;
  localparam logic [1:0] StatusTruncated = 2'd2;

  // Byte format.
  localparam int unsigned SignBitIdx = 7;
  localparam int unsigned EndTagIdx  = 0;

  // Largest number of bytes a value may span in each format.
  localparam logic [3:0] SignedMaxBytes   = 4'd10;
  localparam logic [3:0] UnsignedMaxBytes = 4'd9;

  localparam int unsigned ValueWidth   = 64;
  localparam int unsigned PayloadWidth = 7;

  // One serialised byte with its side information.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       signed_mode;
    logic       buffer_last;
  } in_beat_t;

  // One decoded value.
  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [1:0]                   status;
    logic [3:0]                   byte_count;
  } out_beat_t;

endpackage

@@ rtl/vsd_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_in_stage: input register of the decoder
// Holds one accepted byte beat until the decode step consumes it.
// ----------------------------------------------------------------------------
module vsd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vsd_pkg::in_beat_t in_beat_i,
  input  logic              consume_i,
  output logic              held_valid_o,
  output vsd_pkg::in_beat_t held_beat_o
);

  logic              valid_q;
  logic              valid_d;
  vsd_pkg::in_beat_t beat_q;

  // The register may refill in the same cycle as its content is consumed.
  assign in_ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      beat_q <= in_beat_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_beat_o  = beat_q;

endmodule

@@ rtl/vsd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_decode: per-byte decode step and value state
// Accumulates seven payload bits per byte (six on a signed first byte) and
// forms a result on the end tag, on the byte limit or at the buffer end.
// ----------------------------------------------------------------------------
module vsd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vsd_pkg::in_beat_t  beat_i,
  input  logic               step_i,
  output logic               has_result_o,
  output vsd_pkg::out_beat_t result_o
);

  localparam int unsigned VW = vsd_pkg::ValueWidth;
  localparam int unsigned PW = vsd_pkg::PayloadWidth;

  logic [VW-1:0] acc_q, acc_d;
  logic [3:0]    seen_q, seen_d;
  logic          neg_q, neg_d;
  logic          signed_q, signed_d;

  logic          first;
  logic [PW-1:0] payload;
  logic [VW-1:0] acc_new;
  logic          neg_new;
  logic          signed_new;
  logic [3:0]    count;
  logic [3:0]    limit;
  logic          end_tag;
  logic          too_long;

  // Payload of this byte and the updated accumulator. The shifted value has
  // zero low bits, so inserting the payload is a plain concatenation.
  always_comb begin
    first   = (seen_q == 4'd0);
    payload = beat_i.data_byte[7:1];
    if (first) begin
      signed_new = beat_i.signed_mode;
      if (beat_i.signed_mode) begin
        neg_new = beat_i.data_byte[vsd_pkg::SignBitIdx];
        acc_new = {{(VW-PW+1){1'b0}}, payload[PW-2:0]};
      end else begin
        neg_new = 1'b0;
        acc_new = {{(VW-PW){1'b0}}, payload};
      end
    end else begin
      signed_new = signed_q;
      neg_new    = neg_q;
      acc_new    = {acc_q[VW-PW-1:0], payload};
    end
  end

  assign count    = seen_q + 4'd1;
  assign limit    = signed_new ? vsd_pkg::SignedMaxBytes : vsd_pkg::UnsignedMaxBytes;
  assign end_tag  = beat_i.data_byte[vsd_pkg::EndTagIdx];
  assign too_long = (count >= limit);

  // Result selection: end tag first, then byte limit, then end of buffer.
  always_comb begin
    result_o.byte_count = count;
    result_o.value      = '0;
    result_o.status     = vsd_pkg::StatusOk;
    has_result_o        = 1'b1;
    if (end_tag) begin
      result_o.value = neg_new ? (VW'(0) - acc_new) : acc_new;
    end else if (too_long) begin
      result_o.status = vsd_pkg::StatusTooLong;
    end else if (beat_i.buffer_last) begin
      result_o.status = vsd_pkg::StatusTruncated;
    end else begin
      has_result_o = 1'b0;
    end
  end

  // State update: a result clears the value state, otherwise keep building.
  always_comb begin
    acc_d    = acc_q;
    seen_d   = seen_q;
    neg_d    = neg_q;
    signed_d = signed_q;
    if (step_i) begin
      if (has_result_o) begin
        acc_d    = '0;
        seen_d   = 4'd0;
        neg_d    = 1'b0;
        signed_d = 1'b0;
      end else begin
        acc_d    = acc_new;
        seen_d   = count;
        neg_d    = neg_new;
        signed_d = signed_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      seen_q   <= 4'd0;
      neg_q    <= 1'b0;
      signed_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      neg_q    <= neg_d;
      signed_q <= signed_d;
    end
  end

endmodule

@@ rtl/vsd_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsd_out_reg: result register of the decoder
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module vsd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  vsd_pkg::out_beat_t beat_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vsd_pkg::out_beat_t out_beat_o
);

  logic               valid_q;
  logic               valid_d;
  vsd_pkg::out_beat_t beat_q;

  // The slot is free when empty or when its beat leaves this cycle.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      beat_q <= beat_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

endmodule

@@ rtl/varint_stream_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_stream_decoder_core: big-endian varint decoder, one byte per beat
// Decodes signed and unsigned variable-length integers from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_beat_i) takes one byte
//   per beat with its format bit and an end-of-buffer flag. The output
//   channel (out_valid_o / out_ready_i / out_beat_o) gives one beat per
//   finished value: on the end tag, on reaching the byte limit, or when the
//   buffer ends early. Bytes in the middle of a value produce no beat.
//   A byte is held in the input register, decoded by short logic and written
//   into the result register, which offers the result until it is taken.
//   The block takes one byte every cycle while no result waits for a full
//   result register; throughput is set by the single decode step between
//   the two registers.
//   When the receiver stalls with a result waiting, bytes that produce no
//   result still flow; a byte that produces one waits in the input register
//   and in_ready_o drops until the result register frees.
//   Reset empties both registers and clears the partial value, so the next
//   byte starts a new value.
// ----------------------------------------------------------------------------
module varint_stream_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vsd_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vsd_pkg::out_beat_t out_beat_o
);

  logic               held_valid;
  vsd_pkg::in_beat_t  held_beat;
  logic               has_result;
  vsd_pkg::out_beat_t result;
  logic               out_free;
  logic               step;

  // A held byte advances unless it needs the result register and that is full.
  assign step = held_valid && (!has_result || out_free);

  vsd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .consume_i    (step),
    .held_valid_o (held_valid),
    .held_beat_o  (held_beat)
  );

  vsd_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (held_beat),
    .step_i       (step),
    .has_result_o (has_result),
    .result_o     (result)
  );

  vsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && has_result),
    .beat_i      (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // Error results always carry a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status != vsd_pkg::StatusOk) |-> (out_beat_o.value == '0))
    else $error("error result with non-zero value");

  // A value spans one to ten bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.byte_count != 4'd0) &&
                    (out_beat_o.byte_count <= vsd_pkg::SignedMaxBytes))
    else $error("byte count out of range");

  // Too long is only reported at one of the two byte limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == vsd_pkg::StatusTooLong) |->
      (out_beat_o.byte_count == vsd_pkg::UnsignedMaxBytes) ||
      (out_beat_o.byte_count == vsd_pkg::SignedMaxBytes))
    else $error("too long reported below the byte limit");

  // The input side only stalls while a byte is held and cannot advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> held_valid && has_result && out_valid_o && !out_ready_i)
    else $error("input stalled without cause");

endmodule

@@ bench/tb_varint_stream_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_varint_stream_decoder_core: self-checking bench of the varint decoder
// A directed table of byte beats covers the format extremes, the sign, the
// end tag, the byte limits and the truncated buffer. Random values follow,
// mostly well-formed with random content, the rest broken or noise. Each
// result beat is compared with its table result or a decoder model in the bench.
// ----------------------------------------------------------------------------
module tb_varint_stream_decoder_core;

  // One stimulus row: the byte beat and, where it is obvious, its result.
  typedef struct packed {
    vsd_pkg::in_beat_t  beat;
    logic               typed;
    vsd_pkg::out_beat_t want;
  } stim_row_t;

  localparam int unsigned DirRows     = 29;
  localparam int unsigned RandItems   = 2000;
  localparam int unsigned IdlePercent = 21;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 10;

  localparam logic [1:0] StOk  = vsd_pkg::StatusOk;
  localparam logic [1:0] StLng = vsd_pkg::StatusTooLong;
  localparam logic [1:0] StTrc = vsd_pkg::StatusTruncated;

  // Directed beats: short values, both byte limits and early buffer ends.
  localparam stim_row_t DirTable [DirRows] = '{
    '{'{8'h01, 1'b0, 1'b0}, 1'b1, '{64'sd0,   StOk,  4'd1}},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b1, '{64'sd127, StOk,  4'd1}},
    '{'{8'h01, 1'b1, 1'b0}, 1'b1, '{64'sd0,   StOk,  4'd1}},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b1, '{-64'sd63, StOk,  4'd1}},
    '{'{8'h81, 1'b1, 1'b0}, 1'b1, '{64'sd0,   StOk,  4'd1}},
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{64'sd0,   StTrc, 4'd1}},
    '{'{8'h02, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h03, 1'b0, 1'b1}, 1'b1, '{64'sd129, StOk,  4'd2}},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b1, '{64'sd0,   StLng, 4'd9}},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b1, '{64'sd0,   StLng, 4'd10}},
    '{'{8'h7E, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0, 1'b1}, 1'b1, '{64'sd0,   StTrc, 4'd2}}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  vsd_pkg::in_beat_t  in_beat_i;
  logic               out_valid_o;
  logic               out_ready_i;
  vsd_pkg::out_beat_t out_beat_o;

  varint_stream_decoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // Decoder model state.
  logic [63:0] acc_q;
  logic [3:0]  seen_q;
  logic        neg_q;
  logic        fmt_signed_q;

  stim_row_t          stim_q[$];
  vsd_pkg::out_beat_t expected_values[$];
  int unsigned        in_count;
  int unsigned        sent;
  int unsigned        cyc;
  int unsigned        stall_cycles;
  int unsigned        fail_count;
  bit                 stim_done;
  logic               calm;

  // A stretch of the run in which neither side idles.
  assign calm = (cyc >= 1200) && (cyc < 1700);

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Decodes one byte beat; returns 1 when the beat finishes a value.
  function automatic bit decode_byte(input vsd_pkg::in_beat_t b,
                                     output vsd_pkg::out_beat_t r);
    logic [3:0] count;
    logic [3:0] limit;
    bit         done;
    r    = '0;
    done = 1'b1;
    if (seen_q == 4'd0) begin
      fmt_signed_q = b.signed_mode;
      if (b.signed_mode) begin
        neg_q = b.data_byte[vsd_pkg::SignBitIdx];
        acc_q = {58'd0, b.data_byte[6:1]};
      end else begin
        neg_q = 1'b0;
        acc_q = {57'd0, b.data_byte[7:1]};
      end
    end else begin
      acc_q = (acc_q << vsd_pkg::PayloadWidth) + {57'd0, b.data_byte[7:1]};
    end
    count = seen_q + 4'd1;
    limit = fmt_signed_q ? vsd_pkg::SignedMaxBytes : vsd_pkg::UnsignedMaxBytes;
    r.byte_count = count;
    if (b.data_byte[vsd_pkg::EndTagIdx]) begin
      r.value  = neg_q ? (64'd0 - acc_q) : acc_q;
      r.status = vsd_pkg::StatusOk;
    end else if (count >= limit) begin
      r.status = vsd_pkg::StatusTooLong;
    end else if (b.buffer_last) begin
      r.status = vsd_pkg::StatusTruncated;
    end else begin
      done = 1'b0;
    end
    if (done) begin
      acc_q        = '0;
      seen_q       = '0;
      neg_q        = 1'b0;
      fmt_signed_q = 1'b0;
    end else begin
      seen_q = count;
    end
    return done;
  endfunction

  // Reset and the input side: table first, then random values.
  initial begin
    stim_row_t   row;
    int unsigned roll;
    int unsigned kind;
    int unsigned len;
    bit          mode;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_beat_i   <= '0;
    stim_done    = 1'b0;
    sent         = 0;

    for (int unsigned i = 0; i < DirRows; i++) begin
      stim_q.push_back(DirTable[i]);
    end

    // Random part: mostly well-formed values, some broken, some noise.
    while (stim_q.size() < DirRows + RandItems) begin
      roll = $urandom_range(99);
      row  = '0;
      if (roll < 10) begin
        row.beat.data_byte   = 8'($urandom_range(255));
        row.beat.signed_mode = 1'($urandom_range(1));
        row.beat.buffer_last = ($urandom_range(3) == 0);
        stim_q.push_back(row);
      end else begin
        mode = 1'($urandom_range(1));
        kind = $urandom_range(99);
        if (kind < 70) begin
          len = ($urandom_range(3) == 0) ? $urandom_range(mode ? 10 : 9, 1)
                                         : $urandom_range(3, 1);
        end else if (kind < 85) begin
          len = $urandom_range(mode ? 9 : 8, 1);
        end else begin
          len = mode ? 10 : 9;
        end
        for (int unsigned i = 0; i < len; i++) begin
          row.beat.data_byte    = 8'($urandom_range(255));
          row.beat.data_byte[0] = 1'b0;
          row.beat.signed_mode  = (i == 0) ? mode : 1'($urandom_range(1));
          row.beat.buffer_last  = 1'b0;
          if (i == len - 1) begin
            if (kind < 70) begin
              row.beat.data_byte[0] = 1'b1;
              row.beat.buffer_last  = ($urandom_range(3) == 0);
            end else if (kind < 85) begin
              row.beat.buffer_last = 1'b1;
            end else begin
              row.beat.buffer_last = 1'($urandom_range(1));
            end
          end
          stim_q.push_back(row);
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Offer beats; a beat stays put until the decoder takes it.
    while (!stim_done) begin
      @(posedge clk_i);
      if (in_valid_i && in_ready_o) begin
        sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (sent < stim_q.size() && (calm || $urandom_range(99) >= IdlePercent)) begin
          in_valid_i <= 1'b1;
          in_beat_i  <= stim_q[sent].beat;
        end else begin
          in_valid_i <= 1'b0;
        end
        if (sent == stim_q.size()) begin
          stim_done = 1'b1;
        end
      end
    end
  end

  // Output side back-pressure.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Model update on each accepted byte, result check and stall watchdog.
  always @(posedge clk_i) begin
    vsd_pkg::out_beat_t pred;
    vsd_pkg::out_beat_t want;
    bit                 has_result;
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (in_valid_i && in_ready_o) begin
        has_result = decode_byte(in_beat_i, pred);
        if (has_result) begin
          expected_values.push_back(stim_q[in_count].typed ? stim_q[in_count].want : pred);
        end
        in_count = in_count + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_values.size() == 0) begin
          $error("unexpected result beat: value %0d, status %0d, byte_count %0d",
                 out_beat_o.value, out_beat_o.status, out_beat_o.byte_count);
          fail_count++;
        end else begin
          want = expected_values.pop_front();
          if (out_beat_o.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_beat_o.value);
            fail_count++;
          end
          if (out_beat_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_beat_o.status);
            fail_count++;
          end
          if (out_beat_o.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count,
                   out_beat_o.byte_count);
            fail_count++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  // End of run: wait for every byte and result, let the pipeline settle, report.
  initial begin
    in_count     = 0;
    cyc          = 0;
    stall_cycles = 0;
    fail_count   = 0;
    acc_q        = '0;
    seen_q       = '0;
    neg_q        = 1'b0;
    fmt_signed_q = 1'b0;
    @(posedge clk_i);
    while (!(in_count == stim_q.size() && expected_values.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_values.size() != 0) begin
      $error("results missing: %0d expected beats not seen", expected_values.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
